### hdl/crcs_pkg.sv
// ----------------------------------------------------------------------------
// crcs_pkg - shared types, constants and matrices for the CRC-32 stream
// Holds the reflected IEEE 802.3 polynomial, the lane count and the
// zero-byte advance matrices used by the lanes and the state update.
// ----------------------------------------------------------------------------
package crcs_pkg;

	// Bytes carried by one input transaction (1..8).
	localparam int BYTES_PER_ITEM = 8;

	localparam int DATA_W = 64;
	localparam int CRC_W  = 32;
	localparam int CNT_W  = $clog2(BYTES_PER_ITEM + 1);

	localparam logic [CRC_W-1:0] CRC_POLY_REFL = 32'hEDB8_8320;
	localparam logic [CRC_W-1:0] CRC_ALL_ONES  = 32'hFFFF_FFFF;

	// SHIFT_MAT[n][j] is the register after n zero bytes are folded into a
	// register holding only bit j. The map is linear, so any register is
	// advanced by XOR-ing the columns of its set bits.
	typedef logic [BYTES_PER_ITEM:0][CRC_W-1:0][CRC_W-1:0] shift_mat_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             first;
		logic [CRC_W-1:0] start;
	} item_ctl_t;

	function automatic shift_mat_t build_shift_mat();
		shift_mat_t       m;
		logic [CRC_W-1:0] r;
		for (int n = 0; n <= BYTES_PER_ITEM; n++) begin
			for (int j = 0; j < CRC_W; j++) begin
				r = CRC_W'(1) << j;
				for (int s = 0; s < 8 * n; s++) begin
					r = r[0] ? ((r >> 1) ^ CRC_POLY_REFL) : (r >> 1);
				end
				m[n][j] = r;
			end
		end
		return m;
	endfunction

	localparam shift_mat_t SHIFT_MAT = build_shift_mat();

	// Advance v by n zero bytes.
	function automatic logic [CRC_W-1:0] mat_apply(input logic [CRC_W-1:0] v,
		input logic [CNT_W-1:0] n);
		logic [CRC_W-1:0] r;
		r = '0;
		for (int j = 0; j < CRC_W; j++) begin
			if (v[j]) begin
				r = r ^ SHIFT_MAT[n][j];
			end
		end
		return r;
	endfunction

endpackage

### hdl/crcs_lane.sv
// ----------------------------------------------------------------------------
// crcs_lane - contribution of one data byte
// Folds one byte into a zero register and advances it by the number of
// bytes that follow it in the aligned word.
// ----------------------------------------------------------------------------
module crcs_lane import crcs_pkg::*; (
	input  logic [7:0]       lane_byte,
	input  logic [CNT_W-1:0] lane_shift,
	output logic [CRC_W-1:0] lane_crc
);

	assign lane_crc = mat_apply({{(CRC_W-8){1'b0}}, lane_byte}, lane_shift);

endmodule

### hdl/crcs_merge.sv
// ----------------------------------------------------------------------------
// crcs_merge - combine lane contributions
// XOR of all lane results gives the data part of the CRC update.
// ----------------------------------------------------------------------------
module crcs_merge import crcs_pkg::*; (
	input  logic [BYTES_PER_ITEM-1:0][CRC_W-1:0] lane_crc,
	output logic [CRC_W-1:0]                     data_crc
);

	always_comb begin
		data_crc = '0;
		for (int j = 0; j < BYTES_PER_ITEM; j++) begin
			data_crc = data_crc ^ lane_crc[j];
		end
	end

endmodule

### hdl/crcs_update.sv
// ----------------------------------------------------------------------------
// crcs_update - running CRC register and result stage
// Restarts or continues the register, advances it by the byte count and
// merges the data part; the register doubles as the output holding stage.
// ----------------------------------------------------------------------------
module crcs_update import crcs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  item_ctl_t        ctl_s1,
	input  logic [CRC_W-1:0] data_crc_s1,
	output logic             advance,
	input  logic             out_ready,
	output logic             out_valid,
	output logic [CRC_W-1:0] crc_value
);

	logic [CRC_W-1:0] crc_q;
	logic             out_valid_q;
	logic [CRC_W-1:0] base;
	logic [CRC_W-1:0] crc_next;

	assign advance = valid_s1 && (!out_valid_q || out_ready);

	always_comb begin
		base     = ctl_s1.first ? ~ctl_s1.start : crc_q;
		crc_next = mat_apply(base, ctl_s1.count) ^ data_crc_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= CRC_ALL_ONES;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			crc_q       <= crc_next;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign crc_value = ~crc_q;

endmodule

### hdl/crc32_ieee_stream.sv
// ----------------------------------------------------------------------------
// crc32_ieee_stream - streaming CRC-32, IEEE 802.3 reflected polynomial
// Up to eight bytes per transaction, lowest byte first; one CRC per
// transaction.
// ----------------------------------------------------------------------------
//
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------------
//  in      | in_valid/in_ready  | data_bytes, byte_count, first, start_value
//  out     | out_valid/out_ready| crc_value
//
//  One transaction per cycle sustained while out_ready is high; a result is
//  offered once its input has passed the lane stage register, loaded at the
//  accepting edge, and then the running register, which loads on advance.
//  The feedback loop is the 32x32 XOR advance of the running register.
//  Reset clears the pipeline and sets the register to all ones (CRC zero).
//  A stalled result holds in the output stage while one more input is
//  taken into the lane stage; in_ready drops only when both are full.
//
// Stage 1: the valid bytes are shifted to the top of the word so that missing
// bytes become leading zero bytes. A zero register absorbs leading zeros, so
// the data part is a fixed linear map of the aligned word: each lane takes
// one byte and advances it by the bytes after it, and the merge XORs them.
// Stage 2: the running register (or the restart value) is advanced by the
// byte count and XOR-ed with the data part.
// ----------------------------------------------------------------------------
module crc32_ieee_stream import crcs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [DATA_W-1:0]   data_bytes,
	input  logic [3:0]          byte_count,
	input  logic                first,
	input  logic [CRC_W-1:0]    start_value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [CRC_W-1:0]    crc_value
);

	localparam int LANE_BITS = 8 * BYTES_PER_ITEM;

	logic [CNT_W-1:0]                     count_sat;
	logic [CNT_W-1:0]                     pad_bytes;
	logic [LANE_BITS-1:0]                 aligned;
	logic [BYTES_PER_ITEM-1:0][CRC_W-1:0] lane_crc;
	logic [CRC_W-1:0]                     data_crc;

	logic                                 valid_s1;
	item_ctl_t                            ctl_s1;
	logic [CRC_W-1:0]                     data_crc_s1;
	logic                                 advance;
	logic                                 in_take;

	// Saturate the count at the lane count; bytes above it are dropped.
	assign count_sat = (byte_count > 4'(BYTES_PER_ITEM)) ? CNT_W'(BYTES_PER_ITEM)
		: CNT_W'(byte_count);
	assign pad_bytes = CNT_W'(BYTES_PER_ITEM) - count_sat;

	// Shift the valid bytes to the top; a zero count shifts everything out.
	assign aligned = data_bytes[LANE_BITS-1:0] << {pad_bytes, 3'b000};

	for (genvar j = 0; j < BYTES_PER_ITEM; j++) begin : g_lane
		crcs_lane u_lane (
			.lane_byte  (aligned[8*j +: 8]),
			.lane_shift (CNT_W'(BYTES_PER_ITEM - j)),
			.lane_crc   (lane_crc[j])
		);
	end

	crcs_merge u_merge (
		.lane_crc (lane_crc),
		.data_crc (data_crc)
	);

	// Stage 1 takes a transaction when empty or when it hands its own on.
	assign in_ready = !valid_s1 || advance;
	assign in_take  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload registers: load on take, hold otherwise.
	always_ff @(posedge clk) begin
		if (in_take) begin
			ctl_s1.count <= count_sat;
			ctl_s1.first <= first;
			ctl_s1.start <= start_value;
			data_crc_s1  <= data_crc;
		end
	end

	crcs_update u_update (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s1    (valid_s1),
		.ctl_s1      (ctl_s1),
		.data_crc_s1 (data_crc_s1),
		.advance     (advance),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.crc_value   (crc_value)
	);

endmodule

### hdl/crcs_checker.sv
// ----------------------------------------------------------------------------
// crcs_checker - port-level checks for the CRC-32 stream
// Watches the handshakes and the result timing seen at the top-level ports.
// ----------------------------------------------------------------------------
module crcs_checker import crcs_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [DATA_W-1:0] data_bytes,
	input logic [3:0]        byte_count,
	input logic              first,
	input logic [CRC_W-1:0]  start_value,
	input logic              out_valid,
	input logic              out_ready,
	input logic [CRC_W-1:0]  crc_value
);

	// Hold an offered input transaction, payload unchanged, until taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid &&
			$stable({data_bytes, byte_count, first, start_value}))
		else $error("input transaction changed while stalled");

	// Hold a pending result until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transaction");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(crc_value))
		else $error("stalled result changed");

	// With the output stage empty the input side never stalls.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output stage");

	// A new result follows an accepted input through the lane stage and the running register.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result appeared without matching input");

endmodule

bind crc32_ieee_stream crcs_checker u_crcs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.data_bytes  (data_bytes),
	.byte_count  (byte_count),
	.first       (first),
	.start_value (start_value),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.crc_value   (crc_value)
);

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the streaming CRC-32 block
// Drives byte items under random valid/ready idling and checks every CRC
// against a bit-serial model of the reflected IEEE 802.3 polynomial.
// ----------------------------------------------------------------------------
module testbench import crcs_pkg::*;;

	localparam int CLK_HALF      = 6;
	localparam int RESET_CYCLES  = 8;
	// Cycles without any transaction before the run is declared hung. The
	// long receiver hold-off below stays well under this.
	localparam int STALL_LIMIT   = 2000;
	localparam int HOLD_OFF_LEN  = 250;
	localparam int DRAIN_CYCLES  = 10;
	localparam int ITEM_BYTES    = BYTES_PER_ITEM;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [DATA_W-1:0] data_bytes;
	logic [3:0]        byte_count;
	logic              first;
	logic [CRC_W-1:0]  start_value;
	logic              out_valid;
	logic              out_ready;
	logic [CRC_W-1:0]  crc_value;

	// Model state: the internal (complemented) register, as the block keeps it.
	logic [CRC_W-1:0]  crc_state;
	logic [CRC_W-1:0]  crc_expect_q[$];

	int unsigned       send_idle_pct;
	int unsigned       recv_idle_pct;
	int unsigned       hold_cycles;
	int unsigned       error_count;
	int unsigned       quiet_cycles;

	crc32_ieee_stream dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_bytes  (data_bytes),
		.byte_count  (byte_count),
		.first       (first),
		.start_value (start_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.crc_value   (crc_value)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Fold the valid bytes of one item into the register, lowest byte first,
	// one bit per step. Counts above the item width saturate.
	function automatic logic [CRC_W-1:0] fold_item(input logic [CRC_W-1:0] crc_in,
		input logic [DATA_W-1:0] d, input logic [3:0] n);
		logic [CRC_W-1:0] r;
		int unsigned      lanes;
		r = crc_in;
		lanes = (n > ITEM_BYTES) ? ITEM_BYTES : n;
		for (int i = 0; i < lanes; i++) begin
			r = r ^ {24'h0, d[8*i +: 8]};
			for (int b = 0; b < 8; b++) begin
				r = r[0] ? ((r >> 1) ^ CRC_POLY_REFL) : (r >> 1);
			end
		end
		return r;
	endfunction

	// Offer one transaction and hold it until accepted. Entered and left at a
	// rising edge; valid stays high across back-to-back items, so it is never
	// lowered and raised in the same step. Predict the CRC at acceptance.
	task automatic send_item(input logic [DATA_W-1:0] d, input logic [3:0] n,
		input logic f, input logic [CRC_W-1:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		data_bytes  <= d;
		byte_count  <= n;
		first       <= f;
		start_value <= s;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		if (f) begin
			crc_state = ~s;
		end
		crc_state = fold_item(crc_state, d, n);
		crc_expect_q.push_back(~crc_state);
	endtask

	// Random count: mostly in range, sometimes zero or past the item width.
	function automatic logic [3:0] pick_count();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 84) begin
			return 4'($urandom_range(1, ITEM_BYTES));
		end else if (r < 92) begin
			return 4'd0;
		end
		return 4'($urandom_range(ITEM_BYTES + 1, 15));
	endfunction

	// Messages of a few items each: restart on the first item, continue on
	// the rest. A small share flips the restart flag to break the sequence.
	task automatic send_messages(input int unsigned n_items);
		int unsigned      sent;
		int unsigned      msg_len;
		logic [CRC_W-1:0] seed_crc;
		logic             f;
		sent = 0;
		while (sent < n_items) begin
			msg_len  = $urandom_range(1, 12);
			seed_crc = ($urandom_range(3) == 0) ? CRC_W'($urandom) : '0;
			for (int k = 0; k < msg_len && sent < n_items; k++) begin
				f = (k == 0);
				if ($urandom_range(19) == 0) begin
					f = ~f;
				end
				send_item({$urandom, $urandom}, pick_count(), f,
					f ? seed_crc : CRC_W'($urandom));
				sent++;
			end
		end
	endtask

	// Directed items: known check value, count extremes, restart handling.
	task automatic test_directed();
		// No restart since reset: "123456789" must still give the check value.
		send_item(64'h3837_3635_3433_3231, 4'd8, 1'b0, 32'hDEAD_BEEF);
		send_item(64'hA5A5_A5A5_A5A5_A539, 4'd1, 1'b0, 32'hFFFF_FFFF);
		// Same string again, this time as a fresh restart from zero.
		send_item(64'h3837_3635_3433_3231, 4'd8, 1'b1, 32'h0000_0000);
		send_item(64'h0000_0000_0000_0039, 4'd1, 1'b0, 32'h0);
		// Zero count: the result is just the restart value, then held.
		send_item(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1, 32'h1234_5678);
		send_item(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b0, 32'h0);
		// Continue from a prior CRC with all ones as start.
		send_item(64'h0, 4'd8, 1'b1, 32'hFFFF_FFFF);
		send_item(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0, 32'h0);
		// Counts past the item width saturate.
		send_item(64'h0123_4567_89AB_CDEF, 4'd9, 1'b1, 32'h0);
		send_item(64'hFEDC_BA98_7654_3210, 4'd15, 1'b0, 32'h0);
		// Every count from 1 to 8, with garbage above the count.
		for (int n = 1; n <= ITEM_BYTES; n++) begin
			send_item({$urandom, $urandom}, 4'(n), (n == 1), 32'hCBF4_3926);
		end
		send_item(64'h8000_0000_0000_0001, 4'd8, 1'b1, 32'h8000_0001);
	endtask

	task automatic test_random(input int unsigned send_pct, input int unsigned recv_pct,
		input int unsigned n_items);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		send_messages(n_items);
	endtask

	// Hold the receiver off for a long stretch while items keep coming, so
	// both stages fill and the input stalls.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_cycles   = HOLD_OFF_LEN;
		send_messages(40);
	endtask

	// Receiver: random ready, or a long hold-off when one is requested.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Compare every accepted result with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (crc_expect_q.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual crc_value %08h",
					$time, crc_value);
				error_count++;
			end else begin
				if (crc_value !== crc_expect_q[0]) begin
					$display("%0t: crc_value mismatch: expected %08h, actual %08h",
						$time, crc_expect_q[0], crc_value);
					error_count++;
				end
				void'(crc_expect_q.pop_front());
			end
		end
	end

	// Watchdog: end the run if no transaction moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles + 1 >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles, %0d results pending",
					$time, STALL_LIMIT, crc_expect_q.size());
				$display("** crc32_ieee_stream: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		data_bytes    = '0;
		byte_count    = '0;
		first         = 1'b0;
		start_value   = '0;
		crc_state     = '1;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_cycles   = 0;
		error_count   = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 21;
		recv_idle_pct = 66;
		test_directed();
		test_random(21, 66, 330);
		test_random(66, 21, 330);
		test_backpressure();
		test_random(0, 0, 330);
		in_valid <= 1'b0;

		// Drain, then allow a few more cycles to catch stray results.
		while (crc_expect_q.size() > 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (crc_expect_q.size() > 0) begin
			$display("%0t: %0d expected results never arrived", $time,
				crc_expect_q.size());
			error_count++;
		end
		if (error_count == 0) begin
			$display("** crc32_ieee_stream: PASSED **");
		end else begin
			$display("** crc32_ieee_stream: FAILED **");
		end
		$finish;
	end

endmodule
